// ----- rtl/ptts_pkg.sv -----
// Package for the periodic task tick scheduler.
// Holds sizes, command codes and the controller/datapath link types.
// No dependencies.
package ptts_pkg;

   // Slot and time sizes
   localparam int MAX_SLOTS  = 8;
   localparam int TIME_WIDTH = 16;
   localparam int IDX_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W      = $clog2(MAX_SLOTS + 1);

   // Field widths on the ports
   localparam int CMD_W   = 1;
   localparam int SLOT_W  = 3;
   localparam int WORK_W  = 16;
   localparam int TICK_W  = 32;
   localparam int ACT_W   = 4;

   // Request command codes
   localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
   localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_wr;     // write one slot from the request
      logic tick_start;  // latch slot count, clear the search
      logic scan_step;   // release, compare and advance one slot
      logic charge;      // take one unit of work from the chosen slot
      logic out_load;    // fill the response register, bump the tick count
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_done;   // every active slot has been visited
   } dp_status_type;

endpackage

// ----- rtl/ptts_req_if.sv -----
// Request channel of the periodic task tick scheduler: valid/ready plus payload.
// Depends on ptts_pkg.
interface ptts_req_if import ptts_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [SLOT_W-1:0] task_slot;
   logic [WORK_W-1:0] work_units;
   logic [WORK_W-1:0] release_period;

   modport source (output valid, cmd, task_slot, work_units, release_period, input ready);
   modport sink   (input valid, cmd, task_slot, work_units, release_period, output ready);
endinterface

// ----- rtl/ptts_rsp_if.sv -----
// Response channel of the periodic task tick scheduler: valid/ready plus payload.
// Depends on ptts_pkg.
interface ptts_rsp_if import ptts_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [TICK_W-1:0] tick_number;
   logic [SLOT_W-1:0] chosen_slot;
   logic              idle;

   modport source (output valid, tick_number, chosen_slot, idle, input ready);
   modport sink   (input valid, tick_number, chosen_slot, idle, output ready);
endinterface

// ----- rtl/ptts_ctrl.sv -----
// Controller of the periodic task tick scheduler: sequences load and tick transfers.
// Depends on ptts_pkg; drives the datapath through ctrl_cmd_type.
module ptts_ctrl import ptts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  dp_status_type    status,
   output ctrl_cmd_type     cmd
);

   localparam int STATE_W = 2;
   localparam logic [STATE_W-1:0] ST_IDLE   = 2'd0;
   localparam logic [STATE_W-1:0] ST_SCAN   = 2'd1;
   localparam logic [STATE_W-1:0] ST_CHARGE = 2'd2;
   localparam logic [STATE_W-1:0] ST_OUT    = 2'd3;

   logic [STATE_W-1:0] state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_xfer;
   logic               rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_cmd == CMD_TICK) begin
                  cmd.tick_start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_CHARGE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_CHARGE: begin
            cmd.charge = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // hold until the response register is free
            if (rsp_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A tick transfer always starts a scan
   a_tick_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_cmd == CMD_TICK) |=> (state_ff == ST_SCAN))
      else $error("tick transfer did not start a scan");

   // A new response never overwrites one still waiting
   a_out_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> rsp_free)
      else $error("response register overwritten");

endmodule

// ----- rtl/ptts_dp.sv -----
// Datapath of the periodic task tick scheduler: slot stores, EDF search, tick counter.
// Depends on ptts_pkg; commanded by ptts_ctrl through ctrl_cmd_type.
module ptts_dp import ptts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  logic              csr_we,
   input  logic [ACT_W-1:0]  csr_wdata,
   input  logic [SLOT_W-1:0] req_task_slot,
   input  logic [WORK_W-1:0] req_work_units,
   input  logic [WORK_W-1:0] req_release_period,
   output logic [TICK_W-1:0] rsp_tick_number,
   output logic [SLOT_W-1:0] rsp_chosen_slot,
   output logic              rsp_idle
);

   // Slot stores, undefined until loaded
   logic [TIME_WIDTH-1:0] exec_ff     [MAX_SLOTS];
   logic [TIME_WIDTH-1:0] period_ff   [MAX_SLOTS];
   logic [TIME_WIDTH-1:0] remain_ff   [MAX_SLOTS];
   logic [TIME_WIDTH-1:0] dl_left_ff  [MAX_SLOTS];
   logic [TIME_WIDTH-1:0] phase_ff    [MAX_SLOTS];

   logic [ACT_W-1:0]      active_ff;
   logic [CNT_W-1:0]      limit_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic                  found_ff;
   logic [IDX_W-1:0]      best_ff;
   logic [TIME_WIDTH-1:0] best_dl_ff;
   logic [TICK_W-1:0]     tick_ff;
   logic [TICK_W-1:0]     out_tick_ff;
   logic [SLOT_W-1:0]     out_slot_ff;
   logic                  out_idle_ff;

   logic [CNT_W-1:0]      limit_in;
   logic [IDX_W-1:0]      load_idx;
   logic                  load_ok;
   logic [IDX_W-1:0]      scan_idx;
   logic                  released;
   logic [TIME_WIDTH-1:0] dl_rel;
   logic [TIME_WIDTH-1:0] rem_rel;
   logic                  pick;
   logic [TIME_WIDTH:0]   phase_inc;
   logic [TIME_WIDTH-1:0] phase_next;
   logic [TIME_WIDTH-1:0] dl_next;

   // Clamp the active slot count to the number of slots
   assign limit_in = (int'(active_ff) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(active_ff);
   assign status.scan_done = (idx_ff == limit_ff);

   assign load_idx = req_task_slot[IDX_W-1:0];
   assign load_ok  = (int'(req_task_slot) < MAX_SLOTS);

   // Release, compare and advance the slot under the scan index
   assign scan_idx   = idx_ff[IDX_W-1:0];
   assign released   = (phase_ff[scan_idx] == '0);
   assign dl_rel     = released ? period_ff[scan_idx] : dl_left_ff[scan_idx];
   assign rem_rel    = (released && remain_ff[scan_idx] == '0) ? exec_ff[scan_idx]
                                                               : remain_ff[scan_idx];
   assign pick       = (rem_rel != '0) && (!found_ff || dl_rel <= best_dl_ff);
   assign phase_inc  = {1'b0, phase_ff[scan_idx]} + (TIME_WIDTH+1)'(1);
   assign phase_next = (phase_inc >= {1'b0, period_ff[scan_idx]}) ? '0
                                                                  : phase_inc[TIME_WIDTH-1:0];
   assign dl_next    = (dl_rel != '0) ? dl_rel - TIME_WIDTH'(1) : '0;

   // Slot stores
   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_ok) begin
         exec_ff[load_idx]    <= req_work_units[TIME_WIDTH-1:0];
         period_ff[load_idx]  <= req_release_period[TIME_WIDTH-1:0];
         remain_ff[load_idx]  <= req_work_units[TIME_WIDTH-1:0];
         phase_ff[load_idx]   <= '0;
         dl_left_ff[load_idx] <= req_release_period[TIME_WIDTH-1:0];
      end else if (cmd.scan_step) begin
         remain_ff[scan_idx]  <= rem_rel;
         phase_ff[scan_idx]   <= phase_next;
         dl_left_ff[scan_idx] <= dl_next;
      end else if (cmd.charge && found_ff) begin
         remain_ff[best_ff]   <= remain_ff[best_ff] - TIME_WIDTH'(1);
      end
   end

   // Search state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         limit_ff   <= '0;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         best_ff    <= '0;
         best_dl_ff <= '0;
         tick_ff    <= '0;
      end else begin
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
         if (cmd.tick_start) begin
            limit_ff <= limit_in;
            idx_ff   <= '0;
            found_ff <= 1'b0;
            best_ff  <= '0;
         end else if (cmd.scan_step) begin
            idx_ff <= idx_ff + CNT_W'(1);
            if (pick) begin
               found_ff   <= 1'b1;
               best_ff    <= scan_idx;
               best_dl_ff <= dl_rel;
            end
         end
         if (cmd.out_load) begin
            tick_ff <= tick_ff + TICK_W'(1);
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_tick_ff <= tick_ff;
         out_slot_ff <= found_ff ? SLOT_W'(best_ff) : '0;
         out_idle_ff <= !found_ff;
      end
   end

   assign rsp_tick_number = out_tick_ff;
   assign rsp_chosen_slot = out_slot_ff;
   assign rsp_idle        = out_idle_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= limit_ff)
      else $error("scan index past the active slot count");

   a_limit_clamped: assert property (@(posedge clock) disable iff (reset)
      int'(limit_ff) <= MAX_SLOTS)
      else $error("active slot count not clamped");

   a_best_scanned: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (CNT_W'(best_ff) < idx_ff))
      else $error("chosen slot was not scanned");

endmodule

// ----- rtl/periodic_task_tick_scheduler.sv -----
// Top level of the periodic task tick scheduler: controller plus datapath.
// Depends on ptts_pkg, ptts_req_if, ptts_rsp_if, ptts_ctrl and ptts_dp.
//
// Earliest-deadline-first scheduler for up to eight periodic tasks. A load
// transfer (cmd 0) writes one slot and returns nothing. A tick
// transfer (cmd 1) returns one response with the tick number, the chosen slot
// and an idle flag. After the tick transfer the block steps each active slot
// in turn through the single release/compare/advance step, then sees the end
// of the scan, charges the chosen slot and loads the response register once
// that register is free. An active_tasks above eight counts as eight.
// The input is ready again in the cycle after the response is loaded, so a
// new tick is taken only after the last one is through, and loads every
// cycle while no tick is in progress. A waiting response does not block load
// transfers; the next tick stalls only at its own response. csr_wdata is
// written into active_tasks when csr_we is high; the user must do this only
// while no tick is in progress, as the block itself does not enforce it.
module periodic_task_tick_scheduler import ptts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   ptts_req_if.sink         req_ch,
   ptts_rsp_if.source       rsp_ch,
   input  logic             csr_we,
   input  logic [ACT_W-1:0] csr_wdata
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // Sequence the transfers
   ptts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // Hold the slots and make the decision
   ptts_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctrl_cmd),
      .status             (dp_status),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_task_slot      (req_ch.task_slot),
      .req_work_units     (req_ch.work_units),
      .req_release_period (req_ch.release_period),
      .rsp_tick_number    (rsp_ch.tick_number),
      .rsp_chosen_slot    (rsp_ch.chosen_slot),
      .rsp_idle           (rsp_ch.idle)
   );

endmodule

// ----- tb/periodic_task_tick_scheduler_tb.sv -----
// Testbench for the periodic task tick scheduler: a driver feeds load and tick transfers
// with bursty gaps, a monitor stalls the response side and checks every decision.
// Depends on ptts_pkg, ptts_req_if, ptts_rsp_if and periodic_task_tick_scheduler.
module periodic_task_tick_scheduler_tb;
   import ptts_pkg::*;

   localparam int RANDOM_ITEMS  = 1600;
   localparam int SETTLE_CYCLES = 16;
   localparam int TIMEOUT_UNITS = 800000;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SLOT_W-1:0] slot;
      logic [WORK_W-1:0] work;
      logic [WORK_W-1:0] period;
   } sched_req_type;

   typedef struct packed {
      logic [TICK_W-1:0] tick_number;
      logic [SLOT_W-1:0] chosen_slot;
      logic              idle;
   } decision_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ACT_W-1:0] csr_wdata;

   ptts_req_if req_ch ();
   ptts_rsp_if rsp_ch ();

   periodic_task_tick_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Scheduler state as the testbench sees it
   logic [TIME_WIDTH-1:0] task_exec      [MAX_SLOTS];
   logic [TIME_WIDTH-1:0] task_period    [MAX_SLOTS];
   logic [TIME_WIDTH-1:0] task_remaining [MAX_SLOTS];
   logic [TIME_WIDTH-1:0] task_deadline  [MAX_SLOTS];
   logic [TIME_WIDTH-1:0] task_phase     [MAX_SLOTS];
   logic [TICK_W-1:0]     tick_count;
   logic [ACT_W-1:0]      active_cfg;

   sched_req_type pending_reqs [$];
   decision_type  decisions_due [$];
   sched_req_type on_bus;
   int unsigned error_count;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned rx_cycles;
   int unsigned rx_mode;
   logic steady_sender;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Write one slot: fresh work, phase restarts, deadline one period out
   function automatic void load_slot(logic [SLOT_W-1:0] slot, logic [WORK_W-1:0] work,
                                     logic [WORK_W-1:0] period);
      task_exec[slot]      = work;
      task_period[slot]    = period;
      task_remaining[slot] = work;
      task_phase[slot]     = '0;
      task_deadline[slot]  = period;
   endfunction

   // One tick: release, pick earliest deadline (ties go to the higher slot), charge, advance
   function automatic decision_type schedule_tick();
      decision_type          d;
      int unsigned           n;
      int unsigned           j;
      logic                  found;
      logic [SLOT_W-1:0]     best;
      logic [TIME_WIDTH-1:0] best_dl;
      logic [TIME_WIDTH:0]   next_phase;
      n = (active_cfg > MAX_SLOTS) ? MAX_SLOTS : active_cfg;
      found = 1'b0;
      best = '0;
      best_dl = '0;
      for (j = 0; j < n; j++) begin
         if (task_phase[j] == '0) begin
            task_deadline[j] = task_period[j];
            if (task_remaining[j] == '0)
               task_remaining[j] = task_exec[j];
         end
         if (task_remaining[j] != '0 && (!found || task_deadline[j] <= best_dl)) begin
            found = 1'b1;
            best = SLOT_W'(j);
            best_dl = task_deadline[j];
         end
      end
      if (found)
         task_remaining[best] = task_remaining[best] - 1'b1;
      for (j = 0; j < n; j++) begin
         next_phase = {1'b0, task_phase[j]} + 1'b1;
         task_phase[j] = (next_phase >= {1'b0, task_period[j]}) ? '0 : next_phase[TIME_WIDTH-1:0];
         if (task_deadline[j] != '0)
            task_deadline[j] = task_deadline[j] - 1'b1;
      end
      d.tick_number = tick_count;
      d.chosen_slot = found ? best : '0;
      d.idle = !found;
      tick_count = tick_count + 1'b1;
      return d;
   endfunction

   function automatic void queue_load(logic [SLOT_W-1:0] slot, logic [WORK_W-1:0] work,
                                      logic [WORK_W-1:0] period);
      sched_req_type r;
      r.cmd = CMD_LOAD;
      r.slot = slot;
      r.work = work;
      r.period = period;
      pending_reqs.push_back(r);
   endfunction

   function automatic void queue_tick();
      sched_req_type r;
      r.cmd = CMD_TICK;
      r.slot = SLOT_W'($urandom);
      r.work = WORK_W'($urandom);
      r.period = WORK_W'($urandom);
      pending_reqs.push_back(r);
   endfunction

   // Mostly short tasks that release often; some zero-work, zero-period and full-range noise
   function automatic void random_load();
      logic [WORK_W-1:0] work;
      logic [WORK_W-1:0] period;
      case ($urandom_range(0, 9))
         0: begin
            work = WORK_W'($urandom_range(0, 65535));
            period = WORK_W'($urandom_range(0, 65535));
         end
         1: begin
            work = '0;
            period = WORK_W'($urandom_range(0, 12));
         end
         2: begin
            work = WORK_W'($urandom_range(1, 4));
            period = '0;
         end
         default: begin
            work = WORK_W'($urandom_range(1, 4));
            period = WORK_W'($urandom_range(1, 12));
         end
      endcase
      queue_load(SLOT_W'($urandom_range(0, MAX_SLOTS - 1)), work, period);
   endfunction

   // Hold until every queued item is sent and every decision is back, then let the block settle
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_reqs.size() != 0 || req_ch.valid || decisions_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(logic [ACT_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      active_cfg = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Driver: predict each transfer, then present the next item in bursts with gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (on_bus.cmd == CMD_TICK)
               decisions_due.push_back(schedule_tick());
            else
               load_slot(on_bus.slot, on_bus.work, on_bus.period);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0 || pending_reqs.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_ch.valid <= 1'b0;
            end else begin
               on_bus = pending_reqs.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.cmd <= on_bus.cmd;
               req_ch.task_slot <= on_bus.slot;
               req_ch.work_units <= on_bus.work;
               req_ch.release_period <= on_bus.period;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = steady_sender ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // Monitor: check each response transfer, then pick the next ready value
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (decisions_due.size() == 0) begin
               $display("%0t: unexpected decision, expected none actual tick %0d slot %0d idle %0d",
                        $time, rsp_ch.tick_number, rsp_ch.chosen_slot, rsp_ch.idle);
               error_count++;
            end else begin
               decision_type want;
               want = decisions_due.pop_front();
               if (rsp_ch.tick_number !== want.tick_number) begin
                  $display("%0t: tick_number mismatch, expected %0d actual %0d",
                           $time, want.tick_number, rsp_ch.tick_number);
                  error_count++;
               end
               if (rsp_ch.chosen_slot !== want.chosen_slot) begin
                  $display("%0t: chosen_slot mismatch at tick %0d, expected %0d actual %0d",
                           $time, want.tick_number, want.chosen_slot, rsp_ch.chosen_slot);
                  error_count++;
               end
               if (rsp_ch.idle !== want.idle) begin
                  $display("%0t: idle mismatch at tick %0d, expected %0d actual %0d",
                           $time, want.tick_number, want.idle, rsp_ch.idle);
                  error_count++;
               end
            end
         end
         rx_cycles++;
         if (rx_cycles % 64 == 0)
            rx_mode = $urandom_range(0, 2);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
               default: begin
                  if ($urandom_range(0, 15) == 0) begin
                     stall_left = $urandom_range(1, 20);
                     rsp_ch.ready <= 1'b0;
                  end else begin
                     rsp_ch.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int unsigned generated;
      int unsigned round;
      int unsigned run_len;
      int unsigned k;
      logic [ACT_W-1:0] cfg;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_LOAD;
      req_ch.task_slot = '0;
      req_ch.work_units = '0;
      req_ch.release_period = '0;
      rsp_ch.ready = 1'b0;
      tick_count = '0;
      active_cfg = '0;
      error_count = 0;
      burst_left = 0;
      gap_left = 0;
      stall_left = 0;
      rx_cycles = 0;
      rx_mode = 0;
      steady_sender = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // No active slots: a tick is idle; then fill every slot with edge-case tasks
      write_active('0);
      queue_tick();
      queue_load(3'd0, 16'd0, 16'd5);
      queue_load(3'd1, 16'd3, 16'd0);
      queue_load(3'd2, 16'hFFFF, 16'hFFFF);
      queue_load(3'd3, 16'd2, 16'd4);
      queue_load(3'd4, 16'd1, 16'd1);
      queue_load(3'd5, 16'd2, 16'd4);
      queue_load(3'd6, 16'd1, 16'd3);
      queue_load(3'd7, 16'h5555, 16'hAAAA);
      wait_drained();
      write_active(4'd8);
      repeat (6) queue_tick();
      wait_drained();
      write_active(4'd15);
      repeat (4) queue_tick();
      wait_drained();
      write_active(4'd1);
      queue_load(3'd0, 16'd2, 16'd3);
      repeat (3) queue_tick();

      // Random runs, each under its own slot count; drain before every register write
      generated = 0;
      round = 0;
      while (generated < RANDOM_ITEMS) begin
         wait_drained();
         if (round < 16)
            cfg = ACT_W'(round);
         else if ($urandom_range(0, 3) == 0)
            cfg = ACT_W'($urandom_range(0, 15));
         else
            cfg = ACT_W'($urandom_range(1, MAX_SLOTS));
         write_active(cfg);
         steady_sender = ($urandom_range(0, 3) == 0);
         run_len = $urandom_range(40, 120);
         for (k = 0; k < run_len; k++) begin
            if ($urandom_range(0, 4) == 0)
               random_load();
            else
               queue_tick();
         end
         generated += run_len;
         round++;
      end
      wait_drained();

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
